@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LJ_ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LJ_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/ljpf_pkg.sv @@
// Shared types, constants and the output clipping function of the
// Lennard-Jones pair force pipeline. Depends on nothing.
`default_nettype none

package ljpf_pkg;

  localparam int unsigned InW    = 22;
  localparam int unsigned MagW   = 22;
  localparam int unsigned RW     = 44;
  localparam int unsigned QW     = 29;
  localparam int unsigned DivSteps  = 29;
  localparam int unsigned SqrtSteps = 22;
  localparam int unsigned CmW    = 55;
  localparam int unsigned FmagW  = 57;

  localparam logic [RW-1:0]    NearLimit = 44'h000_1000_0000;
  localparam logic [RW-1:0]    RemInit   = 44'h000_0800_0000;
  localparam logic [58:0]      FmagClamp = 59'h100_0000_0000_0000;
  localparam logic [31:0]      PosMax    = 32'h7FFF_FFFF;
  localparam logic [31:0]      NegMax    = 32'h8000_0000;

  typedef struct packed {
    logic                      valid;
    logic [2:0]                neg;
    logic [2:0][MagW-1:0]      mag;
    logic                      zero;
    logic                      near;
  } carry_t;

  typedef struct packed {
    logic [RW-1:0]   rem;
    logic [QW-1:0]   q;
    logic [RW-1:0]   sv;
    logic [RW-1:0]   sres;
    logic [RW-1:0]   r;
  } iter_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [31:0] energy;
    logic [31:0] virial;
    logic        sat;
  } result_t;

  typedef struct packed {
    logic [31:0] value;
    logic        clip;
  } clip_t;

  function automatic clip_t clip32(input logic neg, input logic [CmW-1:0] mag);
    clip_t o;
    o.clip = 1'b0;
    if (neg) begin
      if (mag > CmW'(NegMax)) begin
        o.clip  = 1'b1;
        o.value = NegMax;
      end else begin
        o.value = 32'(0) - mag[31:0];
      end
    end else begin
      if (mag > CmW'(PosMax)) begin
        o.clip  = 1'b1;
        o.value = PosMax;
      end else begin
        o.value = mag[31:0];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ sv/lennard_jones_pair_force.sv @@
// Lennard-Jones 12-6 pair force pipeline: reciprocal, powers, force, energy
// and virial in fixed point. Depends on ljpf_pkg.
//
// Usage: one pair word (dx, dy, dz, Q5.16) enters on the pair channel when
// pair_valid is high and pair_stall is low. One result word leaves on the
// result channel when result_valid is high and result_stall is low; it holds
// force_x/y/z, pair_energy, virial_term (Q15.16) and the saturated flag.
// Throughput is one pair per cycle while pair_stall is low. The pipeline
// holds 3 stages of magnitude, squaring and summing, 29 stages of the
// bit-per-stage reciprocal divider (the square root runs alongside it),
// 11 multiply stages and the output register, the first of which loads
// at the accepting edge.
// When the receiver stalls, the result register holds and one more word
// lands in a skid register; pair_stall then rises and the whole pipeline
// freezes until the skid register drains. Nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
`default_nettype none

module lennard_jones_pair_force (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pair_valid,
  output logic                     pair_stall,
  input  wire logic signed [21:0]  dx,
  input  wire logic signed [21:0]  dy,
  input  wire logic signed [21:0]  dz,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic signed [31:0]       force_x,
  output logic signed [31:0]       force_y,
  output logic signed [31:0]       force_z,
  output logic signed [31:0]       pair_energy,
  output logic signed [31:0]       virial_term,
  output logic                     saturated
);

  logic en;
  logic skid_valid;
  ljpf_pkg::result_t skid;
  ljpf_pkg::result_t res_l;
  logic res_l_valid;

  assign en = !skid_valid;
  assign pair_stall = skid_valid;

  // Stage 0: sign and magnitude.
  ljpf_pkg::carry_t c0, c1, c2;
  logic [ljpf_pkg::RW-1:0] sq [3];
  logic [ljpf_pkg::RW-1:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.valid <= 1'b0;
    end else if (en) begin
      c0.valid <= pair_valid;
    end
    if (en) begin
      c0.neg  <= {dz[21], dy[21], dx[21]};
      c0.mag[0] <= dx[21] ? 22'(-dx) : 22'(dx);
      c0.mag[1] <= dy[21] ? 22'(-dy) : 22'(dy);
      c0.mag[2] <= dz[21] ? 22'(-dz) : 22'(dz);
      c0.zero <= 1'b0;
      c0.near <= 1'b0;
    end
  end

  // Stage 1: squares. Stage 2: sum and range checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= c0.valid;
      c2.valid <= c1.valid;
    end
    if (en) begin
      c1.neg  <= c0.neg;
      c1.mag  <= c0.mag;
      c1.zero <= 1'b0;
      c1.near <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= c0.mag[i] * c0.mag[i];
      end
      c2.neg  <= c1.neg;
      c2.mag  <= c1.mag;
      r2      <= ljpf_pkg::RW'({2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]});
      c2.zero <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
      c2.near <= ({2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]})
                 < {2'b00, ljpf_pkg::NearLimit};
    end
  end

  // Reciprocal divider, one quotient bit per stage; square root alongside.
  ljpf_pkg::iter_t  it [ljpf_pkg::DivSteps+1];
  ljpf_pkg::carry_t ic [ljpf_pkg::DivSteps+1];

  always_comb begin
    it[0].rem  = ljpf_pkg::RemInit;
    it[0].q    = '0;
    it[0].sv   = r2;
    it[0].sres = '0;
    it[0].r    = r2;
    ic[0]      = c2;
  end

  for (genvar j = 0; j < ljpf_pkg::DivSteps; j++) begin : g_step
    localparam int unsigned K = ljpf_pkg::DivSteps - 1 - j;
    ljpf_pkg::iter_t nx;
    logic [ljpf_pkg::RW:0] t;
    logic [ljpf_pkg::RW:0] st;

    always_comb begin
      nx = it[j];
      t  = {it[j].rem, 1'b0};
      if (t >= {1'b0, it[j].r}) begin
        nx.rem  = ljpf_pkg::RW'(t - {1'b0, it[j].r});
        nx.q[K] = 1'b1;
      end else begin
        nx.rem  = t[ljpf_pkg::RW-1:0];
      end
      st = '0;
      if (j < ljpf_pkg::SqrtSteps) begin
        st = {1'b0, it[j].sres}
             + ((ljpf_pkg::RW+1)'(1) << (2 * (ljpf_pkg::SqrtSteps - 1 - j)));
        if ({1'b0, it[j].sv} >= st) begin
          nx.sv   = ljpf_pkg::RW'({1'b0, it[j].sv} - st);
          nx.sres = ljpf_pkg::RW'({1'b0, it[j].sres >> 1}
                    + ((ljpf_pkg::RW+1)'(1) << (2 * (ljpf_pkg::SqrtSteps - 1 - j))));
        end else begin
          nx.sres = it[j].sres >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ic[j+1].valid <= 1'b0;
      end else if (en) begin
        ic[j+1].valid <= ic[j].valid;
      end
      if (en) begin
        it[j+1] <= nx;
        ic[j+1].neg  <= ic[j].neg;
        ic[j+1].mag  <= ic[j].mag;
        ic[j+1].zero <= ic[j].zero;
        ic[j+1].near <= ic[j].near;
      end
    end
  end

  // Multiply stages.
  ljpf_pkg::carry_t m [1:11];
  logic [ljpf_pkg::QW-1:0] q1, q2r, q3r, q4, q5;
  logic [21:0] d1, d2, d3, d4, d5, d6, d7, d8;
  logic [33:0] pq2;
  logic [38:0] pq3, q3a, q3b;
  logic [58:0] p3lo;
  logic [57:0] p3hi;
  logic [53:0] pq6;
  logic        fneg5, fneg6, fneg7, fneg8, fneg9, fneg10;
  logic        eneg5, eneg6, eneg7, eneg8, eneg9, eneg10;
  logic [47:0] emag5, emag6, emag7, emag8, emag9, emag10;
  logic [49:0] tmag5;
  logic [53:0] p6lo, p6hi;
  logic [78:0] p7;
  logic [82:0] f24;
  logic [ljpf_pkg::FmagW-1:0] fmag8;
  logic [53:0] p9lo [4];
  logic [46:0] p9hi [4];
  logic [ljpf_pkg::CmW-1:0] cm10 [4];
  logic [54:0] rep;
  logic [78:0] s4;

  assign f24 = {p7, 4'b0000} + {1'b0, p7, 3'b000};
  assign rep = {pq6, 1'b0};
  assign s4  = {20'd0, p3lo} + {1'b0, p3hi, 20'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 11; i++) begin
        m[i].valid <= 1'b0;
      end
    end else if (en) begin
      m[1].valid <= ic[ljpf_pkg::DivSteps].valid;
      for (int i = 2; i <= 11; i++) begin
        m[i].valid <= m[i-1].valid;
      end
    end
    if (en) begin
      m[1].neg  <= ic[ljpf_pkg::DivSteps].neg;
      m[1].mag  <= ic[ljpf_pkg::DivSteps].mag;
      m[1].zero <= ic[ljpf_pkg::DivSteps].zero;
      m[1].near <= ic[ljpf_pkg::DivSteps].near;
      for (int i = 2; i <= 11; i++) begin
        m[i].neg  <= m[i-1].neg;
        m[i].mag  <= m[i-1].mag;
        m[i].zero <= m[i-1].zero;
        m[i].near <= m[i-1].near;
      end

      // q^2 and q^3.
      pq2 <= 34'((58'(it[ljpf_pkg::DivSteps].q) * 58'(it[ljpf_pkg::DivSteps].q)) >> 24);
      q1  <= it[ljpf_pkg::DivSteps].q;
      d1  <= it[ljpf_pkg::DivSteps].sres[21:0];
      pq3 <= 39'((63'(pq2) * 63'(q1)) >> 24);
      q2r <= q1;
      d2  <= d1;

      // q^6 from two partial products.
      p3lo <= 59'(pq3) * 59'(pq3[19:0]);
      p3hi <= 58'(pq3) * 58'(pq3[38:20]);
      q3a  <= pq3;
      q3r  <= q2r;
      d3   <= d2;
      pq6  <= s4[77:24];
      q3b  <= q3a;
      q4   <= q3r;
      d4   <= d3;

      // Force term and energy.
      fneg5 <= rep < {16'd0, q3b};
      tmag5 <= (rep < {16'd0, q3b}) ? 50'({16'd0, q3b} - rep) : 50'(rep - {16'd0, q3b});
      eneg5 <= pq6 < {15'd0, q3b};
      emag5 <= (pq6 < {15'd0, q3b}) ? 48'(({15'd0, q3b} - pq6) >> 6)
                                    : 48'((pq6 - {15'd0, q3b}) >> 6);
      q5    <= q4;
      d5    <= d4;

      p6lo  <= 54'(tmag5[24:0]) * 54'(q5);
      p6hi  <= 54'(tmag5[49:25]) * 54'(q5);
      fneg6 <= fneg5;
      eneg6 <= eneg5;
      emag6 <= emag5;
      d6    <= d5;

      p7    <= {25'd0, p6lo} + {p6hi, 25'd0};
      fneg7 <= fneg6;
      eneg7 <= eneg6;
      emag7 <= emag6;
      d7    <= d6;

      fmag8 <= (f24[82:24] > ljpf_pkg::FmagClamp) ? ljpf_pkg::FmagW'(ljpf_pkg::FmagClamp)
                                                  : f24[80:24];
      fneg8 <= fneg7;
      eneg8 <= eneg7;
      emag8 <= emag7;
      d8    <= d7;

      for (int i = 0; i < 3; i++) begin
        p9lo[i] <= 54'(fmag8[31:0]) * 54'(m[8].mag[i]);
        p9hi[i] <= 47'(fmag8[56:32]) * 47'(m[8].mag[i]);
      end
      p9lo[3] <= 54'(fmag8[31:0]) * 54'(d8);
      p9hi[3] <= 47'(fmag8[56:32]) * 47'(d8);
      fneg9 <= fneg8;
      eneg9 <= eneg8;
      emag9 <= emag8;

      for (int i = 0; i < 4; i++) begin
        cm10[i] <= ljpf_pkg::CmW'(({25'd0, p9lo[i]} + {p9hi[i], 32'd0}) >> 24);
      end
      fneg10 <= fneg9;
      eneg10 <= eneg9;
      emag10 <= emag9;
    end
  end

  // Clip and special cases into the last pipeline register.
  ljpf_pkg::clip_t cx, cy, cz, ce, cv;
  ljpf_pkg::result_t res_n;

  always_comb begin
    cx = ljpf_pkg::clip32((fneg10 != m[10].neg[0]) && (cm10[0] != '0), cm10[0]);
    cy = ljpf_pkg::clip32((fneg10 != m[10].neg[1]) && (cm10[1] != '0), cm10[1]);
    cz = ljpf_pkg::clip32((fneg10 != m[10].neg[2]) && (cm10[2] != '0), cm10[2]);
    ce = ljpf_pkg::clip32(eneg10 && (emag10 != '0), ljpf_pkg::CmW'(emag10));
    cv = ljpf_pkg::clip32(fneg10 && (cm10[3] != '0), cm10[3]);
    res_n.fx     = cx.value;
    res_n.fy     = cy.value;
    res_n.fz     = cz.value;
    res_n.energy = ce.value;
    res_n.virial = cv.value;
    res_n.sat    = cx.clip | cy.clip | cz.clip | ce.clip | cv.clip;
    priority if (m[10].zero) begin
      res_n = '0;
      res_n.sat = 1'b1;
    end else if (m[10].near) begin
      res_n.fx = (m[10].mag[0] == '0) ? 32'd0
                 : (m[10].neg[0] ? ljpf_pkg::NegMax : ljpf_pkg::PosMax);
      res_n.fy = (m[10].mag[1] == '0) ? 32'd0
                 : (m[10].neg[1] ? ljpf_pkg::NegMax : ljpf_pkg::PosMax);
      res_n.fz = (m[10].mag[2] == '0) ? 32'd0
                 : (m[10].neg[2] ? ljpf_pkg::NegMax : ljpf_pkg::PosMax);
      res_n.energy = ljpf_pkg::PosMax;
      res_n.virial = ljpf_pkg::PosMax;
      res_n.sat    = 1'b1;
    end else begin
      res_n.sat = res_n.sat;
    end
  end

  assign res_l_valid = m[11].valid;

  always_ff @(posedge clk) begin
    if (en) begin
      res_l <= res_n;
    end
  end

  // Output register with one skid word.
  ljpf_pkg::result_t out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (!result_valid || !result_stall) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          out_r        <= skid;
          skid_valid   <= 1'b0;
        end else begin
          result_valid <= res_l_valid;
          out_r        <= res_l;
        end
      end else if (res_l_valid && !skid_valid) begin
        skid       <= res_l;
        skid_valid <= 1'b1;
      end
    end
  end

  assign force_x     = out_r.fx;
  assign force_y     = out_r.fy;
  assign force_z     = out_r.fz;
  assign pair_energy = out_r.energy;
  assign virial_term = out_r.virial;
  assign saturated   = out_r.sat;

endmodule

`default_nettype wire

@@ sv/ljpf_checker.sv @@
// Port-level checker for the Lennard-Jones pair force pipeline, bound to
// the top level. Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ljpf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               pair_valid,
  input wire logic               pair_stall,
  input wire logic signed [21:0] dx,
  input wire logic signed [21:0] dy,
  input wire logic signed [21:0] dz,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [31:0] force_x,
  input wire logic signed [31:0] force_y,
  input wire logic signed [31:0] force_z,
  input wire logic signed [31:0] pair_energy,
  input wire logic signed [31:0] virial_term,
  input wire logic               saturated
);

  `LJ_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(force_x) && $stable(force_y) && $stable(force_z) && $stable(pair_energy) && $stable(virial_term) && $stable(saturated))
  `LJ_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !result_valid && !pair_stall)
  `LJ_ASSERT_IMPL(a_stall_cause, clk, rst, pair_stall, $past(result_valid && result_stall))

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (.*);

`default_nettype wire

@@ dv/lennard_jones_pair_force_test.sv @@
// Self-checking testbench for the Lennard-Jones pair force pipeline: a directed
// table of displacements followed by random ones, with random idling on both sides.
// Depends on ljpf_pkg and lennard_jones_pair_force.
`default_nettype none

module lennard_jones_pair_force_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 430;
  localparam int QuietFirst = 150;
  localparam int QuietLast = 260;
  localparam int DrainWord = 320;
  localparam int IdleLimit = 5000;
  localparam int TailCycles = 80;

  typedef struct {
    logic signed [21:0] x;
    logic signed [21:0] y;
    logic signed [21:0] z;
    bit                 known;
    ljpf_pkg::result_t  res;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  logic signed [21:0] dx = '0;
  logic signed [21:0] dy = '0;
  logic signed [21:0] dz = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] force_x, force_y, force_z, pair_energy, virial_term;
  logic saturated;

  ljpf_pkg::result_t force_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int near_seen = 0;
  int sat_seen = 0;
  int idle_count = 0;
  bit quiet = 1'b0;
  pair_row_t rows[$];

  lennard_jones_pair_force dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .dx(dx), .dy(dy), .dz(dz),
    .result_valid(result_valid), .result_stall(result_stall),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .pair_energy(pair_energy), .virial_term(virial_term), .saturated(saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] rem, res, t;
    rem = v;
    res = 0;
    for (int b = 44; b >= 0; b -= 2) begin
      t = res + (64'd1 << b);
      if (rem >= t) begin
        rem -= t;
        res = (res >> 1) + (64'd1 << b);
      end else begin
        res >>= 1;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] saturate(bit neg, logic [63:0] m, ref bit sat);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic ljpf_pkg::result_t lj_force(logic signed [21:0] x,
                                                 logic signed [21:0] y,
                                                 logic signed [21:0] z);
    ljpf_pkg::result_t r;
    bit neg[3];
    logic [63:0] mag[3];
    logic [63:0] r2, q, q2, q3, q6, rep, tmag, fmag, emag, span, cm;
    logic [31:0] vals[3];
    bit fneg, eneg, sat;
    logic signed [21:0] c[3];
    c[0] = x;
    c[1] = y;
    c[2] = z;
    r2 = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][21];
      mag[i] = neg[i] ? 64'(-64'(c[i])) : 64'(c[i]);
      r2 += mag[i] * mag[i];
    end
    if (r2 == 0) begin
      r = '0;
      r.sat = 1'b1;
      return r;
    end
    if (r2 < 64'h1000_0000) begin
      for (int i = 0; i < 3; i++)
        vals[i] = (mag[i] == 0) ? 32'd0 : (neg[i] ? ljpf_pkg::NegMax : ljpf_pkg::PosMax);
      r.fx = vals[0];
      r.fy = vals[1];
      r.fz = vals[2];
      r.energy = ljpf_pkg::PosMax;
      r.virial = ljpf_pkg::PosMax;
      r.sat = 1'b1;
      return r;
    end
    q = (64'd1 << 56) / r2;
    q2 = mul_trunc(q, q, 24);
    q3 = mul_trunc(q2, q, 24);
    q6 = mul_trunc(q3, q3, 24);
    rep = 2 * q6;
    fneg = rep < q3;
    tmag = fneg ? q3 - rep : rep - q3;
    fmag = mul_trunc(24 * tmag, q, 24);
    eneg = q6 < q3;
    emag = (4 * (eneg ? q3 - q6 : q6 - q3)) >> 8;
    span = int_sqrt(r2);
    for (int i = 0; i < 3; i++) begin
      cm = mul_trunc(fmag, mag[i], 24);
      vals[i] = saturate((fneg != neg[i]) && cm != 0, cm, sat);
    end
    r.fx = vals[0];
    r.fy = vals[1];
    r.fz = vals[2];
    r.energy = saturate(eneg && emag != 0, emag, sat);
    cm = mul_trunc(fmag, span, 24);
    r.virial = saturate(fneg && cm != 0, cm, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", words_out, what, got, want);
    errors++;
  endtask

  task automatic send_pair(logic signed [21:0] x, logic signed [21:0] y,
                           logic signed [21:0] z, bit known, ljpf_pkg::result_t res);
    pair_valid <= 1'b1;
    dx <= x;
    dy <= y;
    dz <= z;
    @(posedge clk);
    while (pair_stall) @(posedge clk);
    force_q.push_back(known ? res : lj_force(x, y, z));
    if (longint'(x) * x + longint'(y) * y + longint'(z) * z < 64'sh1000_0000) near_seen++;
    words_in++;
    if (!quiet && $urandom_range(99) < 16) begin
      pair_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  function automatic logic signed [21:0] rand_coord();
    logic [21:0] v;
    case ($urandom_range(7))
      0: v = 22'($urandom);
      1: v = 22'($signed(20'($urandom)));
      2: v = 22'($signed(18'($urandom)));
      3: v = 22'($signed(16'($urandom)));
      4: v = 22'($signed(15'($urandom)));
      5: v = 22'd0;
      default: v = 22'(int'($urandom_range(150000)) * ($urandom_range(1) ? 1 : -1));
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    ljpf_pkg::result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (force_q.size() == 0) begin
          $display("unexpected result word %0d", words_out);
          errors++;
        end else begin
          want = force_q.pop_front();
          if (force_x !== want.fx) report("force_x", force_x, want.fx);
          if (force_y !== want.fy) report("force_y", force_y, want.fy);
          if (force_z !== want.fz) report("force_z", force_z, want.fz);
          if (pair_energy !== want.energy) report("pair_energy", pair_energy, want.energy);
          if (virial_term !== want.virial) report("virial_term", virial_term, want.virial);
          if (saturated !== want.sat) report("saturated", saturated, want.sat);
          if (saturated) sat_seen++;
        end
        words_out++;
      end
      result_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if ((pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("[lennard_jones_pair_force] ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    pair_row_t row;
    ljpf_pkg::result_t z;
    z = '0;
    row.known = 1'b1;
    row.res = z;
    row.res.sat = 1'b1;
    row.x = '0; row.y = '0; row.z = '0;
    rows.push_back(row);
    row.res = '{fx: ljpf_pkg::PosMax, fy: 32'd0, fz: ljpf_pkg::NegMax,
                energy: ljpf_pkg::PosMax, virial: ljpf_pkg::PosMax, sat: 1'b1};
    row.x = 22'sd1; row.y = '0; row.z = -22'sd1;
    rows.push_back(row);
    row.res = '{fx: ljpf_pkg::NegMax, fy: ljpf_pkg::PosMax, fz: 32'd0,
                energy: ljpf_pkg::PosMax, virial: ljpf_pkg::PosMax, sat: 1'b1};
    row.x = -22'sd16383; row.y = 22'sd1; row.z = '0;
    rows.push_back(row);
    row.known = 1'b0;
    row.res = z;
    foreach (rows[i]) begin end
    begin
      int tv[15][3] = '{
        '{16384, 0, 0}, '{0, -16384, 0}, '{65536, 0, 0}, '{-73562, 0, 0},
        '{42000, -42000, 42000}, '{30000, 0, -1}, '{2097151, 2097151, 2097151},
        '{-2097152, -2097152, -2097152}, '{-2097152, 0, 2097151},
        '{131072, 65536, -98304}, '{50000, 50000, 0}, '{1, 1, 200000},
        '{0, 0, -2097152}, '{20000, -20000, 5}, '{100000, -3, 7}};
      foreach (tv[i]) begin
        row.x = 22'(tv[i][0]); row.y = 22'(tv[i][1]); row.z = 22'(tv[i][2]);
        rows.push_back(row);
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_pair(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
    for (int n = 0; n < RandomWords; n++) begin
      quiet = (n >= QuietFirst && n < QuietLast);
      if (n == DrainWord) begin
        pair_valid <= 1'b0;
        @(posedge clk);
        while (force_q.size() != 0) @(posedge clk);
      end
      send_pair(rand_coord(), rand_coord(), rand_coord(), 1'b0, z);
    end
    quiet = 1'b0;
    pair_valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d pairs (%0d inside the near limit), checked %0d results, %0d saturated.",
             words_in, near_seen, words_out, sat_seen);
    if (errors == 0) begin
      $display("[lennard_jones_pair_force] OK");
    end else begin
      $display("[lennard_jones_pair_force] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
